// ===== rtl/gcgc_pkg.sv =====
// Shared types and constants for the greedy constraint group colouring core.
`timescale 1ns / 1ps
`default_nettype none

package gcgc_pkg;

	localparam int IDX_W     = 13;  // body index field width
	localparam int COUNT_W   = 3;   // body count field width
	localparam int GIDX_W    = 5;   // group index result width
	localparam int GUSE_W    = 6;   // groups in use result width
	localparam int SLOTS_MAX = 4;   // body fields carried by one beat
	localparam int SLOT_W    = 2;   // selects one of the body fields
	localparam int EPOCH_W   = 8;   // clear generation tag kept per memory word

	typedef struct packed {
		logic              load;    // latch the incoming beat
		logic              clear;   // beat asks for a fresh start
		logic              sweep;   // write one zero word of the clearing pass
		logic              rd;      // issue a mask read for slot
		logic              decide;  // pick the group
		logic              wr;      // write back the mask for slot
		logic              emit;    // load the result register
		logic [SLOT_W-1:0] slot;
	} gcgc_cmd_t;

	typedef struct packed {
		logic epoch_full;  // next clear wraps the tag and needs a clearing pass
		logic sweep_last;  // clearing pass is at its last word
		logic out_free;    // result register can take a new beat
	} gcgc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/gcgc_ctrl.sv =====
// Sequencer for the colouring core: clearing pass, reads, decision, writes, result.
`timescale 1ns / 1ps
`default_nettype none

module gcgc_ctrl #(
	parameter int SLOTS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               start_new,
	input  wire gcgc_pkg::gcgc_sts_t sts,
	output gcgc_pkg::gcgc_cmd_t     cmd,
	output logic                    in_stall
);

	typedef enum logic [6:0] {
		ST_SWEEP  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_WAIT   = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_WRITE  = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} ctrl_state_t;

	localparam logic [gcgc_pkg::SLOT_W-1:0] SLOT_LAST = gcgc_pkg::SLOT_W'(SLOTS - 1);

	ctrl_state_t                   state_q;
	ctrl_state_t                   state_nxt;
	logic [gcgc_pkg::SLOT_W-1:0]   slot_q;
	logic                          pend_q;
	logic                          slot_last;

	assign slot_last = (slot_q == SLOT_LAST);
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.slot  = slot_q;
		state_nxt = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					cmd.clear = start_new;
					state_nxt = (start_new && sts.epoch_full) ? ST_SWEEP : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				if (slot_last) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nxt  = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
				if (slot_last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			slot_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// advance the slot through reads and writes, rewind at the end of each run
			if ((state_q == ST_READ) || (state_q == ST_WRITE)) begin
				slot_q <= slot_last ? '0 : slot_q + 1'b1;
			end else begin
				slot_q <= '0;
			end
			if (cmd.load) begin
				pend_q <= start_new && sts.epoch_full;
			end else if (cmd.sweep && sts.sweep_last) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gcgc_dp.sv =====
// Datapath of the colouring core: mask memory, group count, first-fit pick, result register.
`timescale 1ns / 1ps
`default_nettype none

module gcgc_dp #(
	parameter int NUM_BODIES = 8192,
	parameter int MAX_GROUPS = 32,
	parameter int SLOTS      = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gcgc_pkg::gcgc_cmd_t             cmd,
	output gcgc_pkg::gcgc_sts_t                  sts,
	input  wire logic [gcgc_pkg::COUNT_W-1:0]    body_count,
	input  wire logic [gcgc_pkg::IDX_W-1:0]      body_a,
	input  wire logic [gcgc_pkg::IDX_W-1:0]      body_b,
	input  wire logic [gcgc_pkg::IDX_W-1:0]      body_c,
	input  wire logic [gcgc_pkg::IDX_W-1:0]      body_d,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [gcgc_pkg::GIDX_W-1:0]          group_index,
	output logic                                 opened_group,
	output logic                                 overflow,
	output logic [gcgc_pkg::GUSE_W-1:0]          groups_in_use
);

	localparam int ADDR_W = $clog2(NUM_BODIES);
	localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
	localparam int PICK_W = $clog2(MAX_GROUPS);
	localparam int WIDE_W = ADDR_W + gcgc_pkg::IDX_W;
	localparam int CMP_W  = WIDE_W + 1;
	localparam int WORD_W = gcgc_pkg::EPOCH_W + MAX_GROUPS;

	logic [gcgc_pkg::IDX_W-1:0]   body_in   [gcgc_pkg::SLOTS_MAX];
	logic [WIDE_W-1:0]            ld_wide   [gcgc_pkg::SLOTS_MAX];
	logic [ADDR_W-1:0]            ld_addr   [gcgc_pkg::SLOTS_MAX];
	logic [gcgc_pkg::SLOTS_MAX-1:0] ld_ok;

	logic [ADDR_W-1:0]            addr_q    [gcgc_pkg::SLOTS_MAX];
	logic [gcgc_pkg::SLOTS_MAX-1:0] ok_q;
	logic [MAX_GROUPS-1:0]        old_q     [gcgc_pkg::SLOTS_MAX];

	logic [gcgc_pkg::EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ADDR_W-1:0]            swp_q;

	logic [WORD_W-1:0]            mem [NUM_BODIES];
	logic [WORD_W-1:0]            rd_q;
	logic                         rd_vld_s1;
	logic [gcgc_pkg::SLOT_W-1:0]  rd_slot_s1;
	logic [MAX_GROUPS-1:0]        rd_marks;

	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_a;
	logic [WORD_W-1:0]            mem_wd;
	logic [MAX_GROUPS-1:0]        set_bit;

	logic [MAX_GROUPS-1:0]        busy;
	logic [MAX_GROUPS-1:0]        live;
	logic [MAX_GROUPS-1:0]        free;
	logic [MAX_GROUPS-1:0]        low;
	logic                         found;
	logic                         full;
	logic [PICK_W-1:0]            fidx;

	logic [PICK_W-1:0]            pick_q;
	logic                         opened_q;
	logic                         ovf_q;

	logic                         out_valid_q;
	logic [gcgc_pkg::GIDX_W-1:0]  gidx_q;
	logic                         opened_out_q;
	logic                         ovf_out_q;
	logic [gcgc_pkg::GUSE_W-1:0]  guse_q;
	logic [PICK_W+gcgc_pkg::GIDX_W-1:0] pick_wide;
	logic [CNT_W+gcgc_pkg::GUSE_W-1:0]  cnt_wide;

	assign body_in[0] = body_a;
	assign body_in[1] = body_b;
	assign body_in[2] = body_c;
	assign body_in[3] = body_d;

	// bodies beyond the count or the body range are ignored
	always_comb begin
		for (int k = 0; k < gcgc_pkg::SLOTS_MAX; k++) begin
			ld_wide[k] = WIDE_W'(body_in[k]);
			ld_addr[k] = ld_wide[k][ADDR_W-1:0];
			ld_ok[k]   = (gcgc_pkg::COUNT_W'(k) < body_count) && (k < SLOTS)
				&& (CMP_W'(body_in[k]) < CMP_W'(NUM_BODIES));
		end
	end

	// a word tagged with an older clear generation reads as empty
	assign rd_marks = (rd_q[WORD_W-1 -: gcgc_pkg::EPOCH_W] == epoch_q) ?
		rd_q[MAX_GROUPS-1:0] : '0;

	assign set_bit = MAX_GROUPS'(1) << pick_q;
	assign mem_we  = cmd.sweep || (cmd.wr && ok_q[cmd.slot] && !ovf_q);
	assign mem_a   = cmd.sweep ? swp_q : addr_q[cmd.slot];
	assign mem_wd  = cmd.sweep ? '0 : {epoch_q, old_q[cmd.slot] | set_bit};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_a] <= mem_wd;
		end
		if (cmd.rd) begin
			rd_q <= mem[mem_a];
		end
	end

	// first fit: lowest open group where no body is marked
	always_comb begin
		busy = '0;
		for (int k = 0; k < gcgc_pkg::SLOTS_MAX; k++) begin
			if (ok_q[k]) begin
				busy = busy | old_q[k];
			end
		end
		for (int g = 0; g < MAX_GROUPS; g++) begin
			live[g] = (CNT_W'(g) < cnt_q);
		end
		free  = live & ~busy;
		low   = free & (~free + MAX_GROUPS'(1));
		found = |free;
		fidx  = '0;
		for (int g = 0; g < MAX_GROUPS; g++) begin
			if (low[g]) begin
				fidx = fidx | PICK_W'(g);
			end
		end
	end

	assign full = (cnt_q >= CNT_W'(MAX_GROUPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= '0;
			cnt_q       <= '0;
			swp_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a full tag wraps to zero; the clearing pass then empties every word
			if (cmd.load && cmd.clear) begin
				epoch_q <= epoch_q + 1'b1;
				cnt_q   <= '0;
			end else if (cmd.decide && !found && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.sweep) begin
				swp_q <= sts.sweep_last ? '0 : swp_q + 1'b1;
			end
			rd_vld_s1 <= cmd.rd;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pick_wide = (PICK_W + gcgc_pkg::GIDX_W)'(pick_q);
	assign cnt_wide  = (CNT_W + gcgc_pkg::GUSE_W)'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < gcgc_pkg::SLOTS_MAX; k++) begin
				addr_q[k] <= ld_addr[k];
			end
			ok_q <= ld_ok;
		end
		if (cmd.rd) begin
			rd_slot_s1 <= cmd.slot;
		end
		if (rd_vld_s1) begin
			old_q[rd_slot_s1] <= rd_marks;
		end
		if (cmd.decide) begin
			if (found) begin
				pick_q   <= fidx;
				opened_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else if (full) begin
				pick_q   <= '0;
				opened_q <= 1'b0;
				ovf_q    <= 1'b1;
			end else begin
				pick_q   <= cnt_q[PICK_W-1:0];
				opened_q <= 1'b1;
				ovf_q    <= 1'b0;
			end
		end
		if (cmd.emit) begin
			gidx_q       <= pick_wide[gcgc_pkg::GIDX_W-1:0];
			opened_out_q <= opened_q;
			ovf_out_q    <= ovf_q;
			guse_q       <= cnt_wide[gcgc_pkg::GUSE_W-1:0];
		end
	end

	assign sts.epoch_full = &epoch_q;
	assign sts.sweep_last = (swp_q == ADDR_W'(NUM_BODIES - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign group_index   = gidx_q;
	assign opened_group  = opened_out_q;
	assign overflow      = ovf_out_q;
	assign groups_in_use = guse_q;

endmodule

`default_nettype wire

// ===== rtl/greedy_constraint_group_coloring_core.sv =====
// Top level of the greedy first-fit constraint group colouring core.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  start_new, body_count, body_a..body_d
//  out      source     out_valid/out_stall  group_index, opened_group, overflow, groups_in_use
//
// A constraint is handled in steps on the single-port mask memory: one mask read per body
// slot (min(4, MAX_BODIES_PER_CONSTRAINT) slots), a wait state to land the last read, a
// decide state, one mask write per slot, then an emit state that loads the result register
// once it is free. The input stays closed until the emit state, so a new beat is taken only
// after the previous result is loaded. After reset a clearing pass over all NUM_BODIES words
// empties the memory; in_stall is high throughout. Every 256th start_new wraps the clear tag
// and runs the same pass again. The next beat is accepted while a result waits in the output
// register; a held result only stalls the core once the following one is ready.
`timescale 1ns / 1ps
`default_nettype none

module greedy_constraint_group_coloring_core #(
	parameter int NUM_BODIES                = 8192,
	parameter int MAX_GROUPS                = 32,
	parameter int MAX_BODIES_PER_CONSTRAINT = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          start_new,
	input  wire logic [gcgc_pkg::COUNT_W-1:0]  body_count,
	input  wire logic [gcgc_pkg::IDX_W-1:0]    body_a,
	input  wire logic [gcgc_pkg::IDX_W-1:0]    body_b,
	input  wire logic [gcgc_pkg::IDX_W-1:0]    body_c,
	input  wire logic [gcgc_pkg::IDX_W-1:0]    body_d,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [gcgc_pkg::GIDX_W-1:0]        group_index,
	output logic                               opened_group,
	output logic                               overflow,
	output logic [gcgc_pkg::GUSE_W-1:0]        groups_in_use
);

	localparam int SLOTS = (MAX_BODIES_PER_CONSTRAINT < gcgc_pkg::SLOTS_MAX) ?
		MAX_BODIES_PER_CONSTRAINT : gcgc_pkg::SLOTS_MAX;

	gcgc_pkg::gcgc_cmd_t cmd;
	gcgc_pkg::gcgc_sts_t sts;

	gcgc_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.start_new (start_new),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	gcgc_dp #(
		.NUM_BODIES (NUM_BODIES),
		.MAX_GROUPS (MAX_GROUPS),
		.SLOTS      (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.body_count    (body_count),
		.body_a        (body_a),
		.body_b        (body_b),
		.body_c        (body_c),
		.body_d        (body_d),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.group_index   (group_index),
		.opened_group  (opened_group),
		.overflow      (overflow),
		.groups_in_use (groups_in_use)
	);

	// an accepted beat keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	a_ovf_no_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && opened_group))
		else $error("overflow result also reports an opened group");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.sweep, cmd.rd, cmd.decide, cmd.wr, cmd.emit}))
		else $error("sequencer issued more than one step");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("result register not loaded on emit");

endmodule

`default_nettype wire
